/* rtl/core/lcsw_pkg.sv */
// lcsw_pkg: shared widths, request and register codes, controller/datapath bundles
// for the load-cell serial weigher; no dependencies
package lcsw_pkg;

  localparam int WORD_BITS  = 24;               // converter word length
  localparam int AVG_W      = 24;               // reported average width
  localparam int NET_W      = 25;               // signed net and units width
  localparam int CNT_W      = 8;                // sample count width
  localparam int SUM_W      = WORD_BITS + CNT_W; // accumulator never overflows
  localparam int SCALE_W    = 16;
  localparam int PULSE_W    = 2;
  localparam int REQ_W      = 2;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 16;
  localparam int DIV_W      = (SUM_W > NET_W) ? SUM_W : NET_W;
  localparam int DIV_CNT_W  = $clog2(DIV_W + 1);
  localparam int BIT_CNT_W  = $clog2(WORD_BITS + 1);

  // request codes, anything else is a plain tick
  localparam logic [REQ_W-1:0] REQ_WEIGH = 2'd1;
  localparam logic [REQ_W-1:0] REQ_TARE  = 2'd2;

  // configuration register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_PULSES = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_SCALE  = 2'd1;

  typedef struct packed {
    logic start_op;
    logic start_tare;
    logic clr_shift;
    logic shift_in;
    logic accum;
    logic div_start;
    logic div_net;
    logic avg_take;
    logic units_take;
    logic load_out;
    logic out_sck;
    logic out_busy;
    logic out_done;
  } dp_cmd_t;

  typedef struct packed {
    logic slot_free;
    logic last_sample;
    logic tare_run;
    logic div_done;
  } dp_stat_t;

endpackage

/* rtl/core/lcsw_div.sv */
// lcsw_div: restoring unsigned divider, one quotient bit per cycle
// depends on lcsw_pkg
module lcsw_div import lcsw_pkg::*; (
  input  logic               clk,
  input  logic               rst,
  input  logic               start,
  input  logic [DIV_W-1:0]   dividend,
  input  logic [SCALE_W-1:0] divisor,
  output logic               done,
  output logic [DIV_W-1:0]   quotient
);

  logic [SCALE_W:0]     rem;
  logic [SCALE_W-1:0]   den;
  logic [DIV_CNT_W-1:0] cnt;
  logic                 running;
  logic [SCALE_W:0]     rem_sh;
  logic [SCALE_W+1:0]   diff;

  assign rem_sh = {rem[SCALE_W-1:0], quotient[DIV_W-1]};
  assign diff   = {1'b0, rem_sh} - {2'b00, den};

  always_ff @(posedge clk) begin
    if (rst) begin
      running <= 1'b0;
      done    <= 1'b0;
      cnt     <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        quotient <= dividend;
        rem      <= '0;
        den      <= divisor;
        cnt      <= DIV_CNT_W'(DIV_W);
        running  <= 1'b1;
      end else if (running) begin
        if (!diff[SCALE_W+1]) begin
          rem      <= diff[SCALE_W:0];
          quotient <= {quotient[DIV_W-2:0], 1'b1};
        end else begin
          rem      <= rem_sh;
          quotient <= {quotient[DIV_W-2:0], 1'b0};
        end
        cnt <= cnt - 1'b1;
        if (cnt == DIV_CNT_W'(1)) begin
          running <= 1'b0;
          done    <= 1'b1;
        end
      end
    end
  end

endmodule

/* rtl/core/lcsw_dp.sv */
// lcsw_dp: shift register, accumulator, tare store, shared divider and result register
// depends on lcsw_pkg and lcsw_div
module lcsw_dp import lcsw_pkg::*; (
  input  logic                     clk,
  input  logic                     rst,
  input  dp_cmd_t                  cmd,
  output dp_stat_t                 stat,
  input  logic                     data_pin,
  input  logic [CNT_W-1:0]         sample_count,
  input  logic [SCALE_W-1:0]       scale_divisor,
  input  logic                     out_stall,
  output logic                     out_valid,
  output logic                     sck,
  output logic                     busy_res,
  output logic                     done_res,
  output logic                     done_was_tare,
  output logic [AVG_W-1:0]         average,
  output logic signed [NET_W-1:0]  net_value,
  output logic signed [NET_W-1:0]  units,
  output logic [AVG_W-1:0]         tare_value
);

  logic [WORD_BITS-1:0]    shift_word;
  logic [SUM_W-1:0]        sample_sum;
  logic [CNT_W-1:0]        samples_left;
  logic [CNT_W-1:0]        samples_total;
  logic                    tare_run;
  logic [AVG_W-1:0]        tare_level;
  logic [AVG_W-1:0]        avg_reg;
  logic signed [NET_W-1:0] net_reg;
  logic signed [NET_W-1:0] units_reg;

  logic [CNT_W-1:0]        cnt_eff;
  logic [SCALE_W-1:0]      scale_eff;
  logic [WORD_BITS-1:0]    reading;
  logic [NET_W-1:0]        net_mag;
  logic [DIV_W-1:0]        div_num;
  logic [SCALE_W-1:0]      div_den;
  logic [DIV_W-1:0]        quo;
  logic                    div_done;
  logic [AVG_W-1:0]        q_avg;
  logic [NET_W-1:0]        q_net;

  assign cnt_eff   = (sample_count == '0) ? CNT_W'(1) : sample_count;
  assign scale_eff = (scale_divisor == '0) ? SCALE_W'(1) : scale_divisor;
  // two's complement to offset binary
  assign reading   = shift_word ^ {1'b1, {(WORD_BITS-1){1'b0}}};
  assign net_mag   = net_reg[NET_W-1] ? (~net_reg + 1'b1) : net_reg;
  assign div_num   = cmd.div_net ? DIV_W'(net_mag) : DIV_W'(sample_sum);
  assign div_den   = cmd.div_net ? scale_eff : SCALE_W'(samples_total);
  assign q_avg     = quo[AVG_W-1:0];
  assign q_net     = quo[NET_W-1:0];

  lcsw_div u_div (
    .clk      (clk),
    .rst      (rst),
    .start    (cmd.div_start),
    .dividend (div_num),
    .divisor  (div_den),
    .done     (div_done),
    .quotient (quo)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      shift_word    <= '0;
      sample_sum    <= '0;
      samples_left  <= '0;
      samples_total <= '0;
      tare_run      <= 1'b0;
      tare_level    <= '0;
      out_valid     <= 1'b0;
    end else begin
      if (cmd.start_op) begin
        samples_total <= cnt_eff;
        samples_left  <= cnt_eff;
        sample_sum    <= '0;
        tare_run      <= cmd.start_tare;
      end
      if (cmd.clr_shift) begin
        shift_word <= '0;
      end
      if (cmd.shift_in) begin
        shift_word <= {shift_word[WORD_BITS-2:0], data_pin};
      end
      if (cmd.accum) begin
        sample_sum <= sample_sum + SUM_W'(reading);
        if (samples_left != '0) begin
          samples_left <= samples_left - 1'b1;
        end
      end
      if (cmd.avg_take) begin
        avg_reg <= q_avg;
        net_reg <= $signed({1'b0, tare_level}) - $signed({1'b0, q_avg});
        if (tare_run) begin
          tare_level <= q_avg;
        end
      end
      if (cmd.units_take) begin
        units_reg <= net_reg[NET_W-1] ? $signed(~q_net + 1'b1) : $signed(q_net);
      end
      if (cmd.load_out) begin
        out_valid <= 1'b1;
      end else if (!out_stall) begin
        out_valid <= 1'b0;
      end
    end
  end

  // result payload
  always_ff @(posedge clk) begin
    if (cmd.load_out) begin
      sck           <= cmd.out_sck;
      busy_res      <= cmd.out_busy;
      done_res      <= cmd.out_done;
      done_was_tare <= cmd.out_done & tare_run;
      average       <= cmd.out_done ? avg_reg : '0;
      net_value     <= (cmd.out_done && !tare_run) ? net_reg : '0;
      units         <= (cmd.out_done && !tare_run) ? units_reg : '0;
      tare_value    <= tare_level;
    end
  end

  assign stat.slot_free   = !out_valid || !out_stall;
  assign stat.last_sample = (samples_left[CNT_W-1:1] == '0);
  assign stat.tare_run    = tare_run;
  assign stat.div_done    = div_done;

endmodule

/* rtl/core/lcsw_ctrl.sv */
// lcsw_ctrl: converter phase machine, serial clock level and sequencing of the divides
// depends on lcsw_pkg
module lcsw_ctrl import lcsw_pkg::*; (
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  output logic               in_stall,
  input  logic [REQ_W-1:0]   req_type,
  input  logic               data_pin,
  input  logic [PULSE_W-1:0] pulses_after_word,
  input  dp_stat_t           stat,
  output dp_cmd_t            cmd
);

  // converter phases
  localparam logic [2:0] PH_IDLE   = 3'd0;
  localparam logic [2:0] PH_WAIT   = 3'd1;
  localparam logic [2:0] PH_BIT_HI = 3'd2;
  localparam logic [2:0] PH_BIT_LO = 3'd3;
  localparam logic [2:0] PH_PUL_HI = 3'd4;
  localparam logic [2:0] PH_PUL_LO = 3'd5;

  // item sequencing
  localparam logic [2:0] SQ_RUN      = 3'd0;
  localparam logic [2:0] SQ_AVG_GO   = 3'd1;
  localparam logic [2:0] SQ_AVG_WAIT = 3'd2;
  localparam logic [2:0] SQ_NET_GO   = 3'd3;
  localparam logic [2:0] SQ_NET_WAIT = 3'd4;
  localparam logic [2:0] SQ_EMIT     = 3'd5;

  logic [2:0]           phase, phase_next;
  logic [2:0]           seq, seq_next;
  logic                 sck_level, sck_level_next;
  logic [BIT_CNT_W-1:0] bit_count, bit_count_next;
  logic [BIT_CNT_W-1:0] bit_inc;
  logic [PULSE_W-1:0]   need;
  logic                 accept;
  logic                 fin;

  assign accept   = in_valid && (seq == SQ_RUN) && stat.slot_free;
  assign in_stall = !((seq == SQ_RUN) && stat.slot_free);
  assign bit_inc  = bit_count + 1'b1;
  assign need     = (pulses_after_word == '0) ? PULSE_W'(1) : pulses_after_word;

  always_comb begin
    cmd            = '0;
    phase_next     = phase;
    seq_next       = seq;
    sck_level_next = sck_level;
    bit_count_next = bit_count;
    fin            = 1'b0;
    case (seq)
      SQ_RUN: begin
        if (accept) begin
          case (phase)
            PH_IDLE: begin
              sck_level_next = 1'b0;
              if (req_type == REQ_WEIGH || req_type == REQ_TARE) begin
                cmd.start_op   = 1'b1;
                cmd.start_tare = (req_type == REQ_TARE);
                phase_next     = PH_WAIT;
              end
            end
            PH_WAIT: begin
              if (!data_pin) begin
                bit_count_next = '0;
                cmd.clr_shift  = 1'b1;
                sck_level_next = 1'b1;
                phase_next     = PH_BIT_HI;
              end
            end
            PH_BIT_HI: begin
              cmd.shift_in   = 1'b1;
              bit_count_next = bit_inc;
              sck_level_next = 1'b0;
              phase_next     = PH_BIT_LO;
            end
            PH_BIT_LO: begin
              sck_level_next = 1'b1;
              if (bit_count < BIT_CNT_W'(WORD_BITS)) begin
                phase_next = PH_BIT_HI;
              end else begin
                bit_count_next = '0;
                phase_next     = PH_PUL_HI;
              end
            end
            PH_PUL_HI: begin
              sck_level_next = 1'b0;
              bit_count_next = bit_inc;
              if (bit_inc < BIT_CNT_W'(need)) begin
                phase_next = PH_PUL_LO;
              end else begin
                cmd.accum = 1'b1;
                if (!stat.last_sample) begin
                  phase_next = PH_WAIT;
                end else begin
                  phase_next = PH_IDLE;
                  fin        = 1'b1;
                end
              end
            end
            PH_PUL_LO: begin
              sck_level_next = 1'b1;
              phase_next     = PH_PUL_HI;
            end
            default: begin
              sck_level_next = 1'b0;
              phase_next     = PH_IDLE;
            end
          endcase
          if (fin) begin
            seq_next = SQ_AVG_GO;
          end else begin
            cmd.load_out = 1'b1;
            cmd.out_sck  = sck_level_next;
            cmd.out_busy = (phase_next != PH_IDLE);
          end
        end
      end
      SQ_AVG_GO: begin
        cmd.div_start = 1'b1;
        seq_next      = SQ_AVG_WAIT;
      end
      SQ_AVG_WAIT: begin
        if (stat.div_done) begin
          cmd.avg_take = 1'b1;
          seq_next     = stat.tare_run ? SQ_EMIT : SQ_NET_GO;
        end
      end
      SQ_NET_GO: begin
        cmd.div_start = 1'b1;
        cmd.div_net   = 1'b1;
        seq_next      = SQ_NET_WAIT;
      end
      SQ_NET_WAIT: begin
        cmd.div_net = 1'b1;
        if (stat.div_done) begin
          cmd.units_take = 1'b1;
          seq_next       = SQ_EMIT;
        end
      end
      SQ_EMIT: begin
        if (stat.slot_free) begin
          cmd.load_out = 1'b1;
          cmd.out_sck  = sck_level;
          cmd.out_busy = (phase != PH_IDLE);
          cmd.out_done = 1'b1;
          seq_next     = SQ_RUN;
        end
      end
      default: begin
        seq_next = SQ_RUN;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase     <= PH_IDLE;
      seq       <= SQ_RUN;
      sck_level <= 1'b0;
      bit_count <= '0;
    end else begin
      phase     <= phase_next;
      seq       <= seq_next;
      sck_level <= sck_level_next;
      bit_count <= bit_count_next;
    end
  end

endmodule

/* rtl/core/load_cell_serial_weigher.sv */
// load_cell_serial_weigher: top level, configuration registers and wiring of
// controller and datapath; depends on lcsw_pkg, lcsw_ctrl, lcsw_dp
//
// usage
//   input channel (in_valid/in_stall) carries one tick per transfer: req_type
//   (tick, start weighing, start tare), the sampled data_pin and sample_count
//   every input transfer gives exactly one result transfer on the output
//   channel (out_valid/out_stall): sck level, busy/done flags, the stored tare,
//   and on a finishing tick the average, net value and units
//   ordinary ticks: the result is registered at the transfer edge, and a new
//   tick is taken every cycle while the result slot drains
//   the tick that closes a weighing runs the shared bit-serial divider twice
//   (sum / count, then |net| / scale), and its result is loaded once both are
//   done (for a tare, once its one divide is done)
//   while the result waits under out_stall the slot holds and in_stall rises
//   configuration (cfg_valid/cfg_ready, always ready): index 0 extra pulses,
//   index 1 scale divisor; other indexes are dropped
//   reset (rst, synchronous): idle phase, clock low, tare level zero,
//   extra pulses 1, scale 1, no result pending
module load_cell_serial_weigher import lcsw_pkg::*; (
  input  logic                     clk,
  input  logic                     rst,
  // input channel
  input  logic                     in_valid,
  output logic                     in_stall,
  input  logic [REQ_W-1:0]         req_type,
  input  logic                     data_pin,
  input  logic [CNT_W-1:0]         sample_count,
  // result channel
  output logic                     out_valid,
  input  logic                     out_stall,
  output logic                     sck,
  output logic                     busy_res,
  output logic                     done_res,
  output logic                     done_was_tare,
  output logic [AVG_W-1:0]         average,
  output logic signed [NET_W-1:0]  net_value,
  output logic signed [NET_W-1:0]  units,
  output logic [AVG_W-1:0]         tare_value,
  // configuration write channel
  input  logic                     cfg_valid,
  output logic                     cfg_ready,
  input  logic [CFG_IDX_W-1:0]     cfg_index,
  input  logic [CFG_DATA_W-1:0]    cfg_data
);

  logic [PULSE_W-1:0] pulses_after_word;
  logic [SCALE_W-1:0] scale_divisor;
  dp_cmd_t            cmd;
  dp_stat_t           stat;

  // register writes are always taken
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      pulses_after_word <= PULSE_W'(1);
      scale_divisor     <= SCALE_W'(1);
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        CFG_PULSES: pulses_after_word <= cfg_data[PULSE_W-1:0];
        CFG_SCALE:  scale_divisor     <= cfg_data[SCALE_W-1:0];
        default: begin
          // unmapped index, write dropped
        end
      endcase
    end
  end

  // phase machine, serial clock and divide sequencing
  lcsw_ctrl u_ctrl (
    .clk               (clk),
    .rst               (rst),
    .in_valid          (in_valid),
    .in_stall          (in_stall),
    .req_type          (req_type),
    .data_pin          (data_pin),
    .pulses_after_word (pulses_after_word),
    .stat              (stat),
    .cmd               (cmd)
  );

  // word capture, accumulation, divides and result register
  lcsw_dp u_dp (
    .clk           (clk),
    .rst           (rst),
    .cmd           (cmd),
    .stat          (stat),
    .data_pin      (data_pin),
    .sample_count  (sample_count),
    .scale_divisor (scale_divisor),
    .out_stall     (out_stall),
    .out_valid     (out_valid),
    .sck           (sck),
    .busy_res      (busy_res),
    .done_res      (done_res),
    .done_was_tare (done_was_tare),
    .average       (average),
    .net_value     (net_value),
    .units         (units),
    .tare_value    (tare_value)
  );

endmodule

/* rtl/core/lcsw_checker.sv */
// lcsw_checker: port-level assertions for the weigher and their bind
// depends on lcsw_pkg and load_cell_serial_weigher
module lcsw_checker import lcsw_pkg::*; (
  input logic                    clk,
  input logic                    rst,
  input logic                    out_valid,
  input logic                    out_stall,
  input logic                    busy_res,
  input logic                    done_res,
  input logic                    done_was_tare,
  input logic [AVG_W-1:0]        average,
  input logic signed [NET_W-1:0] net_value,
  input logic signed [NET_W-1:0] units,
  input logic [AVG_W-1:0]        tare_value
);

  // nothing pending right after reset
  a_reset_empty: assert property (@(posedge clk) rst |=> !out_valid)
    else $error("result pending after reset");

  // a finished operation leaves the block idle
  a_done_idle: assert property (@(posedge clk) disable iff (rst)
    out_valid && done_res |-> !busy_res)
    else $error("done reported while still busy");

  // plain ticks carry no measurement
  a_quiet_tick: assert property (@(posedge clk) disable iff (rst)
    out_valid && !done_res |-> average == '0 && net_value == '0 && units == '0
      && !done_was_tare)
    else $error("measurement fields set on a plain tick");

  // a tare stores its own average and reports no net
  a_tare_store: assert property (@(posedge clk) disable iff (rst)
    out_valid && done_res && done_was_tare |-> tare_value == average
      && net_value == '0 && units == '0)
    else $error("tare result inconsistent");

  // stalled result holds
  a_stall_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall |=> out_valid && $stable(units) && $stable(average))
    else $error("stalled result changed");

endmodule

bind load_cell_serial_weigher lcsw_checker u_lcsw_checker (.*);

/* test/lcsw_result_check.sv */
`timescale 1ns / 100ps
// lcsw_result_check: watches the tick, result and register channels of the weigher,
// predicts each result from its own copy of the converter state and compares them
// depends on lcsw_pkg
module lcsw_result_check import lcsw_pkg::*; (
  input  logic                    clk,
  input  logic                    rst,
  input  logic                    in_valid,
  input  logic                    in_stall,
  input  logic [REQ_W-1:0]        req_type,
  input  logic                    data_pin,
  input  logic [CNT_W-1:0]        sample_count,
  input  logic                    out_valid,
  input  logic                    out_stall,
  input  logic                    sck,
  input  logic                    busy_res,
  input  logic                    done_res,
  input  logic                    done_was_tare,
  input  logic [AVG_W-1:0]        average,
  input  logic signed [NET_W-1:0] net_value,
  input  logic signed [NET_W-1:0] units,
  input  logic [AVG_W-1:0]        tare_value,
  input  logic                    cfg_valid,
  input  logic                    cfg_ready,
  input  logic [CFG_IDX_W-1:0]    cfg_index,
  input  logic [CFG_DATA_W-1:0]   cfg_data,
  output int                      fail_count,
  output int                      results_owed
);

  typedef enum logic [2:0] {
    ST_IDLE, ST_WAIT_READY, ST_BIT_HI, ST_BIT_LO, ST_PULSE_HI, ST_PULSE_LO
  } conv_phase_t;

  typedef struct packed {
    logic                    sck;
    logic                    busy;
    logic                    done;
    logic                    was_tare;
    logic [AVG_W-1:0]        avg;
    logic signed [NET_W-1:0] net;
    logic signed [NET_W-1:0] units;
    logic [AVG_W-1:0]        tare_lvl;
  } tick_result_t;

  // two's complement word to offset binary
  localparam logic [WORD_BITS-1:0] SIGN_FLIP = {1'b1, {(WORD_BITS-1){1'b0}}};
  localparam int SHOW_LIMIT = 10;

  conv_phase_t            phase;
  logic                   clk_lvl;
  logic [BIT_CNT_W-1:0]   bit_idx;
  logic [WORD_BITS-1:0]   word_sr;
  logic [SUM_W-1:0]       reading_sum;
  logic [CNT_W-1:0]       readings_left;
  logic [CNT_W-1:0]       readings_total;
  logic                   tare_op;
  logic [AVG_W-1:0]       tare_lvl;
  logic [PULSE_W-1:0]     extra_pulses;
  logic [SCALE_W-1:0]     scale_div;
  tick_result_t           tick_results_due[$];
  int                     shown;

  // advance the converter model by one tick and return what the block reports
  function automatic tick_result_t next_tick_result(input logic [REQ_W-1:0] req,
      input logic pin, input logic [CNT_W-1:0] cnt);
    tick_result_t       r;
    logic [CNT_W-1:0]   n;
    logic [PULSE_W-1:0] need;
    logic [SUM_W-1:0]   quot;
    longint             diff;
    longint             div;
    r = '0;
    case (phase)
      ST_IDLE: begin
        clk_lvl = 1'b0;
        if (req == REQ_WEIGH || req == REQ_TARE) begin
          n = (cnt == '0) ? CNT_W'(1) : cnt;
          readings_total = n;
          readings_left = n;
          reading_sum = '0;
          tare_op = (req == REQ_TARE);
          phase = ST_WAIT_READY;
        end
      end
      ST_WAIT_READY: begin
        if (!pin) begin
          bit_idx = '0;
          word_sr = '0;
          clk_lvl = 1'b1;
          phase = ST_BIT_HI;
        end
      end
      ST_BIT_HI: begin
        word_sr = {word_sr[WORD_BITS-2:0], pin};
        bit_idx = bit_idx + 1'b1;
        clk_lvl = 1'b0;
        phase = ST_BIT_LO;
      end
      ST_BIT_LO: begin
        clk_lvl = 1'b1;
        if (bit_idx < BIT_CNT_W'(WORD_BITS)) begin
          phase = ST_BIT_HI;
        end else begin
          bit_idx = '0;
          phase = ST_PULSE_HI;
        end
      end
      ST_PULSE_HI: begin
        need = (extra_pulses == '0) ? PULSE_W'(1) : extra_pulses;
        clk_lvl = 1'b0;
        bit_idx = bit_idx + 1'b1;
        if (bit_idx < need) begin
          phase = ST_PULSE_LO;
        end else begin
          reading_sum = reading_sum + SUM_W'(word_sr ^ SIGN_FLIP);
          if (readings_left != '0) readings_left = readings_left - 1'b1;
          if (readings_left != '0) begin
            phase = ST_WAIT_READY;
          end else begin
            n = (readings_total == '0) ? CNT_W'(1) : readings_total;
            quot = reading_sum / n;
            r.done = 1'b1;
            r.was_tare = tare_op;
            r.avg = quot[AVG_W-1:0];
            if (tare_op) begin
              tare_lvl = quot[AVG_W-1:0];
            end else begin
              div = (scale_div == '0) ? 64'sd1 : longint'(scale_div);
              diff = longint'(tare_lvl) - longint'(quot[AVG_W-1:0]);
              r.net = diff[NET_W-1:0];
              diff = diff / div;
              r.units = diff[NET_W-1:0];
            end
            phase = ST_IDLE;
          end
        end
      end
      ST_PULSE_LO: begin
        clk_lvl = 1'b1;
        phase = ST_PULSE_HI;
      end
      default: begin
        clk_lvl = 1'b0;
        phase = ST_IDLE;
      end
    endcase
    r.sck = clk_lvl;
    r.busy = (phase != ST_IDLE);
    r.tare_lvl = tare_lvl;
    return r;
  endfunction

  always @(posedge clk) begin
    tick_result_t want;
    tick_result_t got;
    logic         bad;
    if (rst) begin
      phase = ST_IDLE;
      clk_lvl = 1'b0;
      bit_idx = '0;
      word_sr = '0;
      reading_sum = '0;
      readings_left = '0;
      readings_total = '0;
      tare_op = 1'b0;
      tare_lvl = '0;
      extra_pulses = PULSE_W'(1);
      scale_div = SCALE_W'(1);
      tick_results_due.delete();
      shown = 0;
      fail_count = 0;
    end else begin
      if (cfg_valid && cfg_ready) begin
        if (cfg_index == CFG_PULSES) extra_pulses = cfg_data[PULSE_W-1:0];
        else if (cfg_index == CFG_SCALE) scale_div = cfg_data[SCALE_W-1:0];
      end
      if (out_valid && !out_stall) begin
        got.sck = sck;
        got.busy = busy_res;
        got.done = done_res;
        got.was_tare = done_was_tare;
        got.avg = average;
        got.net = net_value;
        got.units = units;
        got.tare_lvl = tare_value;
        if (tick_results_due.size() == 0) begin
          fail_count++;
          if (shown < SHOW_LIMIT) begin
            shown++;
            $display("lcsw_result_check: %0t result transfer with nothing outstanding",
                     $realtime);
          end
        end else begin
          want = tick_results_due.pop_front();
          bad = (got.sck !== want.sck) || (got.busy !== want.busy) ||
                (got.done !== want.done) || (got.was_tare !== want.was_tare) ||
                (got.avg !== want.avg) || (got.net !== want.net) ||
                (got.units !== want.units) || (got.tare_lvl !== want.tare_lvl);
          if (bad) begin
            fail_count++;
            if (shown < SHOW_LIMIT) begin
              shown++;
              $display("lcsw_result_check: %0t mismatch", $realtime);
              $display("  expected sck %b busy %b done %b tare %b avg %h net %0d units %0d lvl %h",
                       want.sck, want.busy, want.done, want.was_tare, want.avg,
                       want.net, want.units, want.tare_lvl);
              $display("  actual   sck %b busy %b done %b tare %b avg %h net %0d units %0d lvl %h",
                       got.sck, got.busy, got.done, got.was_tare, got.avg,
                       got.net, got.units, got.tare_lvl);
            end
          end
        end
      end
      if (in_valid && !in_stall)
        tick_results_due.push_back(next_tick_result(req_type, data_pin, sample_count));
    end
    results_owed = tick_results_due.size();
  end

endmodule

/* test/tb_top.sv */
`timescale 1ns / 100ps
// tb_top: stimulus and verdict for load_cell_serial_weigher; drives converter-like
// tick sequences, register writes and idle/stall patterns; depends on lcsw_pkg,
// lcsw_result_check and the weigher rtl
module tb_top;
  import lcsw_pkg::*;

  // plain tick codes; weighing and tare starts come from the package
  localparam logic [REQ_W-1:0]     REQ_TICK  = 2'd0;
  localparam logic [REQ_W-1:0]     REQ_SPARE = 2'd3;
  // register indexes past the end of the list, writes are dropped
  localparam logic [CFG_IDX_W-1:0] CFG_SPARE_2 = 2'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_SPARE_3 = 2'd3;

  // converter words: top of scale and bottom of scale once flipped to offset binary
  localparam logic [WORD_BITS-1:0] WORD_TOP    = {1'b0, {(WORD_BITS-1){1'b1}}};
  localparam logic [WORD_BITS-1:0] WORD_BOTTOM = {1'b1, {(WORD_BITS-1){1'b0}}};

  localparam int TOTAL_ITEMS  = 1400;
  localparam int IDLE_MODES   = 4;
  localparam int DRAIN_CYCLES = 120;
  localparam int CYCLE_LIMIT  = 600000;

  typedef enum logic [1:0] {IDLE_NONE, IDLE_SENDER, IDLE_RECEIVER, IDLE_BOTH} idle_mode_t;
  typedef enum logic [1:0] {WORDS_RANDOM, WORDS_TOP, WORDS_BOTTOM, WORDS_MIXED} word_mode_t;

  logic                    clk;
  logic                    rst;
  logic                    in_valid;
  logic                    in_stall;
  logic [REQ_W-1:0]        req_type;
  logic                    data_pin;
  logic [CNT_W-1:0]        sample_count;
  logic                    out_valid;
  logic                    out_stall = 1'b0;
  logic                    sck;
  logic                    busy_res;
  logic                    done_res;
  logic                    done_was_tare;
  logic [AVG_W-1:0]        average;
  logic signed [NET_W-1:0] net_value;
  logic signed [NET_W-1:0] units;
  logic [AVG_W-1:0]        tare_value;
  logic                    cfg_valid;
  logic                    cfg_ready;
  logic [CFG_IDX_W-1:0]    cfg_index;
  logic [CFG_DATA_W-1:0]   cfg_data;

  int check_fails;
  int results_owed;
  int cycle_count = 0;
  int send_idle_pct = 0;
  int recv_stall_pct = 0;
  int ticks_sent = 0;
  // extra pulse setting as the block holds it, needed to frame each reading
  logic [PULSE_W-1:0] pulse_setting = PULSE_W'(1);

  load_cell_serial_weigher dut (.*);

  lcsw_result_check u_result_check (
    .fail_count   (check_fails),
    .results_owed (results_owed),
    .*
  );

  always begin
    clk = 1'b0;
    #6;
    clk = 1'b1;
    #6;
  end

  // receiver side: random stalls at the current rate
  always @(posedge clk) begin
    if (rst) out_stall <= 1'b0;
    else out_stall <= ($urandom_range(99, 0) < recv_stall_pct);
  end

  // watchdog
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("tb_top: done, errors");
      $finish;
    end
  end

  task automatic set_idling(input idle_mode_t mode);
    case (mode)
      IDLE_NONE: begin
        send_idle_pct = 0;
        recv_stall_pct = 0;
      end
      IDLE_SENDER: begin
        send_idle_pct = 68;
        recv_stall_pct = 0;
      end
      IDLE_RECEIVER: begin
        send_idle_pct = 0;
        recv_stall_pct = 68;
      end
      default: begin
        send_idle_pct = 33;
        recv_stall_pct = 33;
      end
    endcase
  endtask

  // one tick transfer, with random idle cycles ahead of it
  task automatic send_tick(input logic [REQ_W-1:0] rq, input logic pin,
                           input logic [CNT_W-1:0] cnt);
    while ($urandom_range(99, 0) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    req_type <= rq;
    data_pin <= pin;
    sample_count <= cnt;
    do @(posedge clk); while (in_stall);
    ticks_sent++;
  endtask

  // request code on a tick inside an operation: mostly plain, sometimes a stray start
  function automatic logic [REQ_W-1:0] busy_req();
    if ($urandom_range(3, 0) != 0) return REQ_TICK;
    case ($urandom_range(2, 0))
      0: return REQ_WEIGH;
      1: return REQ_TARE;
      default: return REQ_SPARE;
    endcase
  endfunction

  task automatic busy_tick(input logic pin);
    send_tick(busy_req(), pin, CNT_W'($urandom));
  endtask

  function automatic logic [WORD_BITS-1:0] pick_word(input word_mode_t mode);
    case (mode)
      WORDS_TOP: return WORD_TOP;
      WORDS_BOTTOM: return WORD_BOTTOM;
      WORDS_MIXED: begin
        case ($urandom_range(4, 0))
          0: return WORD_TOP;
          1: return WORD_BOTTOM;
          2: return '0;
          3: return '1;
          default: return WORD_BITS'($urandom);
        endcase
      end
      default: return WORD_BITS'($urandom);
    endcase
  endfunction

  // one converter reading: optional not-ready stretch, data low, then 24 clocked
  // bits (pin matters only on the rising half) and the gain-select pulses
  task automatic run_reading(input logic [WORD_BITS-1:0] word);
    int not_ready;
    int pulses;
    int b;
    not_ready = ($urandom_range(3, 0) == 0) ? $urandom_range(6, 1) : 0;
    repeat (not_ready) busy_tick(1'b1);
    busy_tick(1'b0);
    for (b = WORD_BITS - 1; b >= 0; b--) begin
      busy_tick(word[b]);
      busy_tick(1'($urandom_range(1, 0)));
    end
    pulses = (pulse_setting == '0) ? 1 : int'(pulse_setting);
    repeat (2 * pulses - 1) busy_tick(1'($urandom_range(1, 0)));
  endtask

  // start transfer, all readings, then a few plain ticks at idle
  task automatic run_op(input logic [REQ_W-1:0] rq, input logic [CNT_W-1:0] cnt,
                        input word_mode_t mode);
    int readings;
    readings = (cnt == '0) ? 1 : int'(cnt);
    send_tick(rq, 1'($urandom_range(1, 0)), cnt);
    repeat (readings) run_reading(pick_word(mode));
    repeat ($urandom_range(2, 0))
      send_tick(($urandom_range(1, 0) == 0) ? REQ_TICK : REQ_SPARE,
                1'($urandom_range(1, 0)), CNT_W'($urandom));
  endtask

  // register write once the block is drained and every result is in
  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx,
                           input logic [CFG_DATA_W-1:0] data);
    in_valid <= 1'b0;
    do @(negedge clk); while (results_owed != 0);
    @(posedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= data;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    if (idx == CFG_PULSES) pulse_setting = data[PULSE_W-1:0];
  endtask

  initial begin
    int op_idx;
    int pick;
    logic [CNT_W-1:0] cnt;
    rst <= 1'b1;
    in_valid <= 1'b0;
    req_type <= REQ_TICK;
    data_pin <= 1'b0;
    sample_count <= '0;
    cfg_valid <= 1'b0;
    cfg_index <= CFG_PULSES;
    cfg_data <= '0;
    repeat (9) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // directed part, no idling
    set_idling(IDLE_NONE);
    send_tick(REQ_TICK, 1'b0, '0);
    send_tick(REQ_SPARE, 1'b1, '1);          // code three at idle is just a tick
    send_tick(REQ_TICK, 1'b1, 8'h5A);
    write_reg(CFG_PULSES, 16'd3);
    write_reg(CFG_SCALE, 16'hFFFF);
    run_op(REQ_TARE, 8'd1, WORDS_TOP);       // tare at the top of the scale
    run_op(REQ_WEIGH, 8'd0, WORDS_BOTTOM);   // zero count, largest positive net
    write_reg(CFG_PULSES, 16'd0);            // zero pulses behave as one
    write_reg(CFG_SCALE, 16'd0);             // zero divisor behaves as one
    run_op(REQ_TARE, 8'd2, WORDS_BOTTOM);
    run_op(REQ_WEIGH, 8'd1, WORDS_TOP);      // most negative net
    write_reg(CFG_PULSES, 16'hFFFE);         // upper bits dropped, two pulses
    write_reg(CFG_SPARE_2, 16'h0001);
    write_reg(CFG_SPARE_3, 16'hFFFF);
    write_reg(CFG_SCALE, 16'd7);
    run_op(REQ_WEIGH, 8'd3, WORDS_MIXED);    // negative quotients truncate toward zero
    write_reg(CFG_PULSES, 16'd1);
    run_op(REQ_WEIGH, 8'd6, WORDS_TOP);      // long run, sum well past the word width

    // random part: well-formed operations with random content and stray requests,
    // cycling through the idle patterns one operation at a time
    op_idx = 0;
    while (ticks_sent < TOTAL_ITEMS || op_idx < IDLE_MODES) begin
      if ($urandom_range(2, 0) == 0) begin
        case ($urandom_range(5, 0))
          0: write_reg(CFG_PULSES, CFG_DATA_W'($urandom));
          1: write_reg(CFG_PULSES, CFG_DATA_W'($urandom_range(3, 0)));
          2: write_reg(CFG_SCALE, CFG_DATA_W'($urandom));
          3: write_reg(CFG_SCALE, CFG_DATA_W'($urandom_range(300, 0)));
          4: write_reg(CFG_SCALE, '1);
          default: write_reg(($urandom_range(1, 0) == 0) ? CFG_SPARE_2 : CFG_SPARE_3,
                             CFG_DATA_W'($urandom));
        endcase
      end
      set_idling(idle_mode_t'(op_idx % IDLE_MODES));
      pick = $urandom_range(9, 0);
      if (pick < 5) cnt = CNT_W'(1);
      else if (pick < 8) cnt = CNT_W'($urandom_range(3, 2));
      else if (pick < 9) cnt = '0;
      else cnt = CNT_W'($urandom_range(6, 4));
      run_op(($urandom_range(3, 0) == 0) ? REQ_TARE : REQ_WEIGH, cnt,
             ($urandom_range(3, 0) == 0) ? WORDS_MIXED : WORDS_RANDOM);
      op_idx++;
    end

    // drain and verdict
    in_valid <= 1'b0;
    do @(negedge clk); while (results_owed != 0);
    repeat (DRAIN_CYCLES) @(negedge clk);
    if (check_fails == 0 && results_owed == 0) begin
      $display("tb_top: done, clean");
    end else begin
      $display("tb_top: done, errors");
    end
    $finish;
  end

endmodule
